### rtl/core/ffva_pkg.sv
// Package: shared types, constants and register codes for the first-free voice allocator.
`default_nettype none
package ffva_pkg;

    localparam int VOICE_COUNT_DEF = 64;

    localparam int RATE_W   = 24;
    localparam int LEN_W    = 24;
    localparam int OFF_W    = 18;
    localparam int CNT_IN_W = 7;
    localparam int VOICE_W  = 7;
    localparam int OFFO_W   = 16;
    localparam int PROD_W   = RATE_W + LEN_W;
    localparam int TIME_W   = 40;
    localparam int BUSY_W   = 56;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [RATE_W-1:0]   RATE_RST   = 24'd3145728;
    localparam logic [CNT_IN_W-1:0] ACTIVE_RST = 7'd64;
    localparam logic                CFI_RST    = 1'b0;

    localparam logic [TIME_W-1:0] ONE_SAMPLE = 40'd65536;
    localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

    localparam logic [1:0] REG_RATE   = 2'd0;
    localparam logic [1:0] REG_ACTIVE = 2'd1;
    localparam logic [1:0] REG_CFI    = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_RST_CLR,
        ST_SCAN,
        ST_WRITE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic scan;
        logic write;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic req;
        logic hit;
        logic exhausted;
        logic out_busy;
    } status_t;

endpackage
`default_nettype wire

### rtl/core/first_free_voice_allocator.sv
// Top level: first-free voice allocator with APB register port.
//
// One input item is one audio sample tick (s_ valid/ready channel); each item
// yields exactly one result item (m_ valid/ready channel) with the assigned
// 1-based voice number and the length and clamped offset used, or all zeros when no voice is granted.
// Registers rate_per_ms, active_count and count_from_input sit at byte
// addresses 0, 4 and 8 of the APB port; pready is always high.
// Items are handled one at a time. An item takes an accept step, a scan of
// the active voices (one memory read per cycle through the single busy-until
// memory port), a write step when a free voice is found, and a result step.
// An item with restart set first clears all VOICE_COUNT memory entries, one
// per cycle.
// After reset the block clears all VOICE_COUNT memory entries with s_ready
// low; time and the APB registers return to their reset values.
// The result register lets the next item be accepted while a result waits;
// that item holds in its result cycle until m_ready takes the earlier one.
`default_nettype none
module first_free_voice_allocator #(
    parameter int VOICE_COUNT = ffva_pkg::VOICE_COUNT_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [ffva_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [ffva_pkg::DATA_W-1:0]         pwdata,
    output logic [ffva_pkg::DATA_W-1:0]              prdata,
    output logic                                     pready,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_trigger,
    input  wire logic [ffva_pkg::LEN_W-1:0]          s_length_ms,
    input  wire logic signed [ffva_pkg::OFF_W-1:0]   s_sub_offset,
    input  wire logic [ffva_pkg::CNT_IN_W-1:0]       s_active_in,
    input  wire logic                                s_restart,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [ffva_pkg::VOICE_W-1:0]             m_voice_number,
    output logic [ffva_pkg::LEN_W-1:0]               m_length_out,
    output logic [ffva_pkg::OFFO_W-1:0]              m_offset_out
);

    logic [ffva_pkg::RATE_W-1:0]   rate_reg;
    logic [ffva_pkg::CNT_IN_W-1:0] active_reg;
    logic                          cfi_reg;
    logic                          wr_en;
    logic [1:0]                    reg_idx;

    ffva_pkg::cmd_t    cmd;
    ffva_pkg::status_t status;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg   <= ffva_pkg::RATE_RST;
            active_reg <= ffva_pkg::ACTIVE_RST;
            cfi_reg    <= ffva_pkg::CFI_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                ffva_pkg::REG_RATE:   rate_reg   <= pwdata[ffva_pkg::RATE_W-1:0];
                ffva_pkg::REG_ACTIVE: active_reg <= pwdata[ffva_pkg::CNT_IN_W-1:0];
                ffva_pkg::REG_CFI:    cfi_reg    <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ffva_pkg::REG_RATE:   prdata = ffva_pkg::DATA_W'(rate_reg);
            ffva_pkg::REG_ACTIVE: prdata = ffva_pkg::DATA_W'(active_reg);
            ffva_pkg::REG_CFI:    prdata = ffva_pkg::DATA_W'(cfi_reg);
            default:              prdata = '0;
        endcase
    end

    ffva_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_restart (s_restart),
        .s_ready   (s_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ffva_dpath #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .rate_per_ms      (rate_reg),
        .active_count     (active_reg),
        .count_from_input (cfi_reg),
        .s_trigger        (s_trigger),
        .s_length_ms      (s_length_ms),
        .s_sub_offset     (s_sub_offset),
        .s_active_in      (s_active_in),
        .s_restart        (s_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_voice_number   (m_voice_number),
        .m_length_out     (m_length_out),
        .m_offset_out     (m_offset_out)
    );

endmodule
`default_nettype wire

### rtl/core/ffva_ctrl.sv
// Controller: sequences clearing, scan, write-back and result hand-off for each item.
`default_nettype none
module ffva_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_restart,
    output logic                  s_ready,
    input  ffva_pkg::status_t     status,
    output ffva_pkg::cmd_t        cmd
);

    ffva_pkg::state_t state_reg;
    ffva_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffva_pkg::ST_INIT_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ffva_pkg::ST_INIT_CLR: begin
                cmd.clear = 1'b1;
                if (status.clr_last) begin
                    state_next = ffva_pkg::ST_IDLE;
                end
            end
            ffva_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = s_restart ? ffva_pkg::ST_RST_CLR : ffva_pkg::ST_SCAN;
                end
            end
            ffva_pkg::ST_RST_CLR: begin
                cmd.clear = 1'b1;
                if (status.clr_last) begin
                    state_next = ffva_pkg::ST_SCAN;
                end
            end
            ffva_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
                priority if (!status.req) begin
                    state_next = ffva_pkg::ST_FINISH;
                end else if (status.hit) begin
                    state_next = ffva_pkg::ST_WRITE;
                end else if (status.exhausted) begin
                    state_next = ffva_pkg::ST_FINISH;
                end
            end
            ffva_pkg::ST_WRITE: begin
                cmd.write  = 1'b1;
                state_next = ffva_pkg::ST_FINISH;
            end
            ffva_pkg::ST_FINISH: begin
                if (!status.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ffva_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ffva_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/ffva_dpath.sv
// Datapath: busy-until memory, time counter, span arithmetic and result register.
`default_nettype none
module ffva_dpath #(
    parameter int VOICE_COUNT = ffva_pkg::VOICE_COUNT_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  ffva_pkg::cmd_t                           cmd,
    output ffva_pkg::status_t                        status,
    input  wire logic [ffva_pkg::RATE_W-1:0]         rate_per_ms,
    input  wire logic [ffva_pkg::CNT_IN_W-1:0]       active_count,
    input  wire logic                                count_from_input,
    input  wire logic                                s_trigger,
    input  wire logic [ffva_pkg::LEN_W-1:0]          s_length_ms,
    input  wire logic signed [ffva_pkg::OFF_W-1:0]   s_sub_offset,
    input  wire logic [ffva_pkg::CNT_IN_W-1:0]       s_active_in,
    input  wire logic                                s_restart,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [ffva_pkg::VOICE_W-1:0]             m_voice_number,
    output logic [ffva_pkg::LEN_W-1:0]               m_length_out,
    output logic [ffva_pkg::OFFO_W-1:0]              m_offset_out
);

    localparam int IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int CW = $clog2(VOICE_COUNT + 1);
    localparam int AW = (CW > ffva_pkg::CNT_IN_W) ? CW : ffva_pkg::CNT_IN_W;
    localparam int SW = ffva_pkg::TIME_W + 1;

    logic [ffva_pkg::BUSY_W-1:0] mem [VOICE_COUNT];

    logic [CW-1:0]                    cnt_reg;
    logic                             cmp_valid_reg;
    logic [IW-1:0]                    cmp_idx_reg;
    logic [ffva_pkg::BUSY_W-1:0]      rd_data_reg;
    logic                             found_reg;
    logic [IW-1:0]                    found_idx_reg;
    logic                             req_reg;
    logic [ffva_pkg::LEN_W-1:0]       len_reg;
    logic [ffva_pkg::OFFO_W-1:0]      off_reg;
    logic [CW-1:0]                    active_reg;
    logic [ffva_pkg::TIME_W-1:0]      now_reg;
    logic [ffva_pkg::TIME_W-1:0]      now_next;
    logic [ffva_pkg::PROD_W-1:0]      prod_reg;
    logic [SW-1:0]                    sum_reg;
    logic                             m_valid_reg;
    logic [ffva_pkg::VOICE_W-1:0]     voice_reg;
    logic [ffva_pkg::LEN_W-1:0]       len_out_reg;
    logic [ffva_pkg::OFFO_W-1:0]      off_out_reg;

    logic [ffva_pkg::CNT_IN_W-1:0]    act_sel;
    logic [AW-1:0]                    act_ext;
    logic [AW-1:0]                    act_cap;
    logic                             off_neg;
    logic                             in_req;
    logic                             scan_more;
    logic                             hit;
    logic [SW-1:0]                    end_time;
    logic [AW-1:0]                    voice_num;

    always_comb begin
        act_sel = count_from_input ? s_active_in : active_count;
        act_ext = AW'(act_sel);
        act_cap = (act_ext > AW'(VOICE_COUNT)) ? AW'(VOICE_COUNT) : act_ext;
        off_neg = s_sub_offset[ffva_pkg::OFF_W-1];
        in_req  = s_trigger && (off_neg || (s_sub_offset[ffva_pkg::OFF_W-2:16] == '0));
        scan_more = cnt_reg < active_reg;
        hit = cmp_valid_reg && (rd_data_reg <= ffva_pkg::BUSY_W'(now_reg));
        end_time = (sum_reg >= SW'(off_reg)) ? (sum_reg - SW'(off_reg)) : '0;
        voice_num = AW'(found_idx_reg) + AW'(1);
        now_next = (now_reg > (ffva_pkg::TIME_MAX - ffva_pkg::ONE_SAMPLE)) ?
                   ffva_pkg::TIME_MAX : (now_reg + ffva_pkg::ONE_SAMPLE);
    end

    always_comb begin
        status.clr_last  = cnt_reg == CW'(VOICE_COUNT - 1);
        status.req       = req_reg;
        status.hit       = hit;
        status.exhausted = !scan_more && !cmp_valid_reg;
        status.out_busy  = m_valid_reg && !m_ready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            mem[cnt_reg[IW-1:0]] <= '0;
        end else if (cmd.write) begin
            mem[found_idx_reg] <= ffva_pkg::BUSY_W'(end_time);
        end
        rd_data_reg <= mem[cnt_reg[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            now_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.load) begin
                cnt_reg       <= '0;
                cmp_valid_reg <= 1'b0;
                found_reg     <= 1'b0;
                if (s_restart) begin
                    now_reg <= '0;
                end
            end else if (cmd.clear) begin
                cnt_reg       <= status.clr_last ? '0 : cnt_reg + CW'(1);
                cmp_valid_reg <= 1'b0;
            end else if (cmd.scan) begin
                cmp_valid_reg <= scan_more;
                if (scan_more) begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                if (hit) begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.finish) begin
                now_reg     <= now_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= ffva_pkg::PROD_W'(rate_per_ms) * ffva_pkg::PROD_W'(len_reg);
        sum_reg  <= SW'(now_reg) + SW'(prod_reg[ffva_pkg::PROD_W-1:8]);
        if (cmd.load) begin
            req_reg    <= in_req;
            len_reg    <= s_length_ms;
            off_reg    <= off_neg ? '0 : s_sub_offset[ffva_pkg::OFFO_W-1:0];
            active_reg <= CW'(act_cap);
        end
        if (cmd.scan) begin
            cmp_idx_reg <= cnt_reg[IW-1:0];
            if (hit) begin
                found_idx_reg <= cmp_idx_reg;
            end
        end
        if (cmd.finish) begin
            voice_reg   <= found_reg ? voice_num[ffva_pkg::VOICE_W-1:0] : '0;
            len_out_reg <= found_reg ? len_reg : '0;
            off_out_reg <= found_reg ? off_reg : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_voice_number = voice_reg;
    assign m_length_out   = len_out_reg;
    assign m_offset_out   = off_out_reg;

endmodule
`default_nettype wire

### verif/ffva_grant_scoreboard_pkg.sv
// Scoreboard package: expected voice grants computed from each accepted sample tick.
package ffva_grant_scoreboard_pkg;
    import ffva_pkg::*;

    typedef struct packed {
        logic                trigger;
        logic [LEN_W-1:0]    length_ms;
        logic [OFF_W-1:0]    sub_offset;
        logic [CNT_IN_W-1:0] active_in;
        logic                restart;
    } tick_t;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic [LEN_W-1:0]   length;
        logic [OFFO_W-1:0]  offset;
    } grant_t;

    class grant_scoreboard;
        logic [BUSY_W-1:0]   busy_until [VOICE_COUNT_DEF];
        logic [TIME_W-1:0]   now_time;
        logic [RATE_W-1:0]   rate;
        logic [CNT_IN_W-1:0] active_cnt;
        logic                count_from_in;
        grant_t              pending_grants [$];
        int unsigned         errors;

        function new();
            free_voices();
            rate          = RATE_RST;
            active_cnt    = ACTIVE_RST;
            count_from_in = CFI_RST;
            errors        = 0;
        endfunction

        function void free_voices();
            foreach (busy_until[i]) busy_until[i] = '0;
            now_time = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_RATE: begin
                    rate = val[RATE_W-1:0];
                end
                REG_ACTIVE: begin
                    active_cnt = val[CNT_IN_W-1:0];
                end
                REG_CFI: begin
                    count_from_in = val[0];
                end
                default: begin
                end
            endcase
        endfunction

        function void note_tick(tick_t t);
            grant_t              g;
            int unsigned         act;
            int                  hit;
            logic [OFFO_W-1:0]   off;
            logic [PROD_W-1:0]   prod;
            logic [TIME_W:0]     fin;
            g   = '0;
            hit = -1;
            if (t.restart) free_voices();
            act = count_from_in ? t.active_in : active_cnt;
            if (act > VOICE_COUNT_DEF) act = VOICE_COUNT_DEF;
            // offset below one sample: negative, or bit 16 clear
            if (t.trigger && (t.sub_offset[OFF_W-1] || !t.sub_offset[OFFO_W])) begin
                off = t.sub_offset[OFF_W-1] ? '0 : t.sub_offset[OFFO_W-1:0];
                for (int i = 0; i < act; i++) begin
                    if (hit < 0 && busy_until[i] <= BUSY_W'(now_time)) hit = i;
                end
                if (hit >= 0) begin
                    prod = PROD_W'(rate) * PROD_W'(t.length_ms);
                    fin  = (TIME_W+1)'(now_time) + (TIME_W+1)'(prod[PROD_W-1:8]);
                    fin  = (fin >= (TIME_W+1)'(off)) ? fin - (TIME_W+1)'(off) : '0;
                    busy_until[hit] = BUSY_W'(fin);
                    g.voice  = VOICE_W'(hit + 1);
                    g.length = t.length_ms;
                    g.offset = off;
                end
            end
            if (now_time > TIME_MAX - ONE_SAMPLE) now_time = TIME_MAX;
            else now_time = now_time + ONE_SAMPLE;
            pending_grants.push_back(g);
        endfunction

        function void check_grant(grant_t got);
            grant_t exp;
            if (pending_grants.size() == 0) begin
                errors++;
                $display("%0t: unexpected item voice %0d length %0d offset %0d",
                         $time, got.voice, got.length, got.offset);
                return;
            end
            exp = pending_grants.pop_front();
            if (got.voice !== exp.voice) begin
                errors++;
                $display("%0t: voice_number expected %0d got %0d", $time, exp.voice, got.voice);
            end
            if (got.length !== exp.length) begin
                errors++;
                $display("%0t: length_out expected %0d got %0d", $time, exp.length, got.length);
            end
            if (got.offset !== exp.offset) begin
                errors++;
                $display("%0t: offset_out expected %0d got %0d", $time, exp.offset, got.offset);
            end
        endfunction
    endclass

endpackage

### verif/first_free_voice_allocator_test.sv
// Testbench top: drives sample ticks and register writes, checks every voice grant.
module first_free_voice_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ffva_pkg::*;
    import ffva_grant_scoreboard_pkg::*;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel, penable, pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  s_valid, s_ready;
    logic                  s_trigger;
    logic [LEN_W-1:0]      s_length_ms;
    logic signed [OFF_W-1:0] s_sub_offset;
    logic [CNT_IN_W-1:0]   s_active_in;
    logic                  s_restart;
    logic                  m_valid, m_ready;
    logic [VOICE_W-1:0]    m_voice_number;
    logic [LEN_W-1:0]      m_length_out;
    logic [OFFO_W-1:0]     m_offset_out;

    int unsigned           src_idle_pct  = 0;
    int unsigned           sink_stall_pct = 0;
    grant_scoreboard       grants;

    always #2 aclk = ~aclk;

    first_free_voice_allocator DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_trigger     (s_trigger),
        .s_length_ms   (s_length_ms),
        .s_sub_offset  (s_sub_offset),
        .s_active_in   (s_active_in),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_voice_number(m_voice_number),
        .m_length_out  (m_length_out),
        .m_offset_out  (m_offset_out)
    );

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            grants.check_grant({m_voice_number, m_length_out, m_offset_out});
    end

    function automatic tick_t make_tick(logic trig, int unsigned len, int off,
                                        int unsigned act, logic rst);
        tick_t t;
        t.trigger    = trig;
        t.length_ms  = LEN_W'(len);
        t.sub_offset = OFF_W'(off);
        t.active_in  = CNT_IN_W'(act);
        t.restart    = rst;
        return t;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        grants.write_reg(idx, val);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic push_tick(input tick_t t);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_trigger    = t.trigger;
        s_length_ms  = t.length_ms;
        s_sub_offset = t.sub_offset;
        s_active_in  = t.active_in;
        s_restart    = t.restart;
        do @(posedge aclk); while (!s_ready);
        grants.note_tick(t);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (grants.pending_grants.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic reconfigure(input logic [RATE_W-1:0] rate, input logic [CNT_IN_W-1:0] act,
                               input logic cfi, input int unsigned idle,
                               input int unsigned stall);
        drain();
        write_reg(REG_RATE, DATA_W'(rate));
        write_reg(REG_ACTIVE, DATA_W'(act));
        write_reg(REG_CFI, DATA_W'(cfi));
        src_idle_pct   = idle;
        sink_stall_pct = stall;
    endtask

    task automatic run_random(input int unsigned count);
        tick_t t;
        repeat (count) begin
            t.trigger   = ($urandom_range(0, 9) < 7);
            t.length_ms = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom)
                                                      : LEN_W'($urandom_range(0, 1024));
            case ($urandom_range(0, 9))
                0: t.sub_offset = OFF_W'($urandom);
                1: t.sub_offset = OFF_W'(-$urandom_range(1, 131072));
                default: t.sub_offset = OFF_W'($urandom_range(0, 65535));
            endcase
            t.active_in = ($urandom_range(0, 4) == 0) ? CNT_IN_W'($urandom)
                                                      : CNT_IN_W'($urandom_range(0, 16));
            t.restart   = ($urandom_range(0, 49) == 0);
            push_tick(t);
        end
    endtask

    initial begin
        grants       = new();
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_valid      = 1'b0;
        s_trigger    = 1'b0;
        s_length_ms  = '0;
        s_sub_offset = '0;
        s_active_in  = '0;
        s_restart    = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        // hold until the post-reset clear is done
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);

        reconfigure(RATE_RST, ACTIVE_RST, CFI_RST, 0, 0);
        push_tick(make_tick(1'b1, 256, 0, 0, 1'b0));
        push_tick(make_tick(1'b1, 24'hFFFFFF, 65535, 127, 1'b0));
        push_tick(make_tick(1'b1, 256, 65536, 0, 1'b0));
        push_tick(make_tick(1'b1, 256, 131071, 0, 1'b0));
        push_tick(make_tick(1'b1, 256, -131072, 0, 1'b0));
        push_tick(make_tick(1'b1, 256, -1, 0, 1'b0));
        push_tick(make_tick(1'b0, 24'hFFFFFF, 0, 0, 1'b1));
        push_tick(make_tick(1'b1, 0, 0, 0, 1'b0));
        push_tick(make_tick(1'b1, 0, 0, 0, 1'b0));
        push_tick(make_tick(1'b1, 1, 32768, 64, 1'b0));

        reconfigure(RATE_RST, 7'd2, 1'b0, 0, 0);
        push_tick(make_tick(1'b1, 2560, 0, 0, 1'b0));
        push_tick(make_tick(1'b1, 2560, 0, 0, 1'b0));
        push_tick(make_tick(1'b1, 2560, 0, 0, 1'b0));
        push_tick(make_tick(1'b0, 2560, 0, 0, 1'b0));
        push_tick(make_tick(1'b1, 2560, 100, 0, 1'b1));

        reconfigure(RATE_RST, 7'd0, 1'b1, 0, 0);
        push_tick(make_tick(1'b1, 256, 0, 0, 1'b0));
        push_tick(make_tick(1'b1, 256, 0, 127, 1'b0));
        push_tick(make_tick(1'b1, 256, 0, 64, 1'b0));
        push_tick(make_tick(1'b1, 256, 0, 1, 1'b0));
        push_tick(make_tick(1'b1, 256, 0, 65, 1'b0));

        reconfigure(RATE_RST, 7'd8, 1'b0, 0, 0);
        run_random(200);
        reconfigure(RATE_W'($urandom), 7'd64, 1'b1, 51, 0);
        run_random(200);
        reconfigure(24'hFFFFFF, 7'd127, 1'b0, 0, 51);
        run_random(150);
        reconfigure(24'd0, 7'd4, 1'b0, 25, 25);
        run_random(150);
        reconfigure(RATE_W'($urandom), 7'd0, 1'b0, 51, 51);
        run_random(40);
        reconfigure(RATE_W'($urandom_range(1 << 16, 64 << 16)), 7'd16, 1'b1, 25, 25);
        run_random(250);

        s_valid = 1'b0;
        while (grants.pending_grants.size() != 0) @(negedge aclk);
        repeat (100) @(posedge aclk);
        if (grants.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
